FILE: src/hhf_pkg.sv
// hhf_pkg: shared types and constants for the http head framer
// parse phases, byte roles, framing characters and the host name table
// no dependencies
package hhf_pkg;

    // parse phase of the message head
    typedef enum logic [3:0] {
        PH_START   = 4'd0,
        PH_CR      = 4'd1,
        PH_NL      = 4'd2,
        PH_HDR     = 4'd3,
        PH_COLON   = 4'd4,
        PH_SPACE   = 4'd5,
        PH_VALUE   = 4'd6,
        PH_CREMPTY = 4'd7,
        PH_DONE    = 4'd8
    } t_phase;

    // role reported for each byte
    typedef logic [2:0] t_role;
    localparam t_role ROLE_START = 3'd0;
    localparam t_role ROLE_EOL   = 3'd1;
    localparam t_role ROLE_NAME  = 3'd2;
    localparam t_role ROLE_SEP   = 3'd3;
    localparam t_role ROLE_VALUE = 3'd4;
    localparam t_role ROLE_FINAL = 3'd5;

    // framing characters
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // status code limits
    localparam int unsigned  ACC_W   = 20;
    localparam logic [15:0] CODE_MAX = 16'hFFFF;

    // register word index of response_mode
    localparam logic REG_RESPONSE_MODE = 1'b0;

    // characters of the header name that marks the host value
    localparam logic [2:0] HOST_LEN = 3'd4;

    function automatic logic [7:0] host_char(input logic [1:0] idx);
        logic [7:0] ch;
        case (idx)
            2'd0:    ch = 8'h48; // H
            2'd1:    ch = 8'h6F; // o
            2'd2:    ch = 8'h73; // s
            default: ch = 8'h74; // t
        endcase
        return ch;
    endfunction

endpackage

FILE: src/http_header_framer_core.sv
// http_header_framer_core: byte-at-a-time framer for an http message head
// input register, single-pass parse logic, result register; apb register port
// depends on hhf_pkg
//
// an item passes through the input register, then the result register; parse state updates once
// per item in the single pass logic; throughput: one item per cycle while i_out_stall is low
// reset: synchronous active-low i_rst_n clears the valid bits of both pipeline stages, parse state
// and response_mode; the input register is empty after reset, so o_in_stall is low
module http_header_framer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_new_message,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_byte_role,
    output logic        o_name_start,
    output logic        o_value_start,
    output logic        o_host_value,
    output logic [15:0] o_status_code,
    output logic        o_status_valid,
    output logic        o_parse_error,
    output logic        o_head_done,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned ACC_W_L = hhf_pkg::ACC_W;

    // configuration register
    logic r_response_mode;

    // pipeline registers
    logic         r_in_valid;
    logic [7:0]   r_in_byte;
    logic         r_in_new;
    logic         r_out_valid;
    hhf_pkg::t_role r_role;
    logic         r_name_start;
    logic         r_value_start;
    logic         r_host_value;
    logic [15:0]  r_status_code;
    logic         r_status_valid;
    logic         r_parse_error;
    logic         r_head_done;

    // parse state
    hhf_pkg::t_phase r_phase, n_phase;
    logic [1:0]   r_spaces, n_spaces;
    logic [15:0]  r_accum, n_accum;
    logic         r_digits_open, n_digits_open;
    logic [2:0]   r_match_cnt, n_match_cnt;
    logic         r_mismatch, n_mismatch;
    logic         r_host_active, n_host_active;
    logic         r_error, n_error;

    // per-item results
    hhf_pkg::t_role n_role;
    logic         n_name_start, n_value_start, n_host_value, n_head_done;
    logic [15:0]  n_status_code;
    logic         n_status_valid;

    logic         advance;
    logic         in_take;
    logic         cfg_write;

    // handshake: result register drains, input register refills
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign in_take    = !r_in_valid || advance;
    assign o_in_stall = !in_take;

    // apb register access
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == hhf_pkg::REG_RESPONSE_MODE);
    assign prdata    = (paddr[2] == hhf_pkg::REG_RESPONSE_MODE) ?
                       {31'd0, r_response_mode} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_response_mode <= 1'b0;
        end else if (cfg_write) begin
            r_response_mode <= pwdata[0];
        end
    end

    // single-pass parse of the byte in the input register
    always_comb begin
        logic [7:0]          ch;
        logic                bad;
        logic [ACC_W_L-1:0]  prod;
        hhf_pkg::t_phase     c_phase;
        logic [1:0]          c_spaces;
        logic [15:0]         c_accum;
        logic                c_digits_open;
        logic [2:0]          c_match_cnt;
        logic                c_mismatch;
        logic                c_host_active;
        logic                c_error;

        ch  = r_in_byte;
        bad = 1'b0;

        // start of a new head clears the parse state
        if (r_in_new) begin
            c_phase       = hhf_pkg::PH_START;
            c_spaces      = 2'd0;
            c_accum       = 16'd0;
            c_digits_open = 1'b1;
            c_match_cnt   = 3'd0;
            c_mismatch    = 1'b0;
            c_host_active = 1'b0;
            c_error       = 1'b0;
        end else begin
            c_phase       = r_phase;
            c_spaces      = r_spaces;
            c_accum       = r_accum;
            c_digits_open = r_digits_open;
            c_match_cnt   = r_match_cnt;
            c_mismatch    = r_mismatch;
            c_host_active = r_host_active;
            c_error       = r_error;
        end

        prod = ({4'd0, c_accum} << 3) + ({4'd0, c_accum} << 1)
             + {12'd0, ch - hhf_pkg::CH_ZERO};

        n_phase       = c_phase;
        n_spaces      = c_spaces;
        n_accum       = c_accum;
        n_digits_open = c_digits_open;
        n_match_cnt   = c_match_cnt;
        n_mismatch    = c_mismatch;
        n_host_active = c_host_active;
        n_error       = c_error;
        n_role        = hhf_pkg::ROLE_START;
        n_name_start  = 1'b0;
        n_value_start = 1'b0;
        n_host_value  = 1'b0;
        n_head_done   = 1'b0;

        if (!c_error) begin
            case (c_phase)
                hhf_pkg::PH_START: begin
                    if (ch == hhf_pkg::CH_LF) begin
                        bad = 1'b1;
                    end else if (ch == hhf_pkg::CH_CR) begin
                        if (c_spaces < 2'd2) begin
                            bad = 1'b1;
                        end else begin
                            n_role  = hhf_pkg::ROLE_EOL;
                            n_phase = hhf_pkg::PH_CR;
                        end
                    end else if (ch == hhf_pkg::CH_SPACE) begin
                        if (c_spaces < 2'd2) n_spaces = c_spaces + 2'd1;
                    end else if (c_spaces == 2'd1 && c_digits_open) begin
                        // status digits between the first and second space
                        if (ch >= hhf_pkg::CH_ZERO && ch <= hhf_pkg::CH_NINE) begin
                            n_accum = (prod > {4'd0, hhf_pkg::CODE_MAX}) ?
                                      hhf_pkg::CODE_MAX : prod[15:0];
                        end else begin
                            n_digits_open = 1'b0;
                        end
                    end
                end
                hhf_pkg::PH_CR: begin
                    if (ch == hhf_pkg::CH_LF) begin
                        n_role  = hhf_pkg::ROLE_EOL;
                        n_phase = hhf_pkg::PH_NL;
                    end else begin
                        bad = 1'b1;
                    end
                end
                hhf_pkg::PH_NL: begin
                    if (ch == hhf_pkg::CH_CR) begin
                        n_role  = hhf_pkg::ROLE_FINAL;
                        n_phase = hhf_pkg::PH_CREMPTY;
                    end else if (ch == hhf_pkg::CH_LF || ch == hhf_pkg::CH_SPACE ||
                                 ch == hhf_pkg::CH_COLON) begin
                        bad = 1'b1;
                    end else begin
                        // first name byte restarts the host compare
                        n_role        = hhf_pkg::ROLE_NAME;
                        n_name_start  = 1'b1;
                        n_host_active = 1'b0;
                        if (ch == hhf_pkg::host_char(2'd0)) begin
                            n_match_cnt = 3'd1;
                            n_mismatch  = 1'b0;
                        end else begin
                            n_match_cnt = 3'd0;
                            n_mismatch  = 1'b1;
                        end
                        n_phase = hhf_pkg::PH_HDR;
                    end
                end
                hhf_pkg::PH_HDR: begin
                    if (ch == hhf_pkg::CH_COLON) begin
                        n_role        = hhf_pkg::ROLE_SEP;
                        n_host_active = !c_mismatch && (c_match_cnt == hhf_pkg::HOST_LEN);
                        n_phase       = hhf_pkg::PH_COLON;
                    end else if (ch == hhf_pkg::CH_SPACE || ch == hhf_pkg::CH_CR ||
                                 ch == hhf_pkg::CH_LF) begin
                        bad = 1'b1;
                    end else begin
                        n_role = hhf_pkg::ROLE_NAME;
                        if (!c_mismatch && c_match_cnt < hhf_pkg::HOST_LEN &&
                            ch == hhf_pkg::host_char(c_match_cnt[1:0])) begin
                            n_match_cnt = c_match_cnt + 3'd1;
                        end else begin
                            n_mismatch = 1'b1;
                        end
                    end
                end
                hhf_pkg::PH_COLON: begin
                    if (ch == hhf_pkg::CH_SPACE) begin
                        n_role  = hhf_pkg::ROLE_SEP;
                        n_phase = hhf_pkg::PH_SPACE;
                    end else begin
                        bad = 1'b1;
                    end
                end
                hhf_pkg::PH_SPACE: begin
                    if (ch == hhf_pkg::CH_CR || ch == hhf_pkg::CH_LF ||
                        ch == hhf_pkg::CH_COLON || ch == hhf_pkg::CH_SPACE) begin
                        bad = 1'b1;
                    end else begin
                        n_role        = hhf_pkg::ROLE_VALUE;
                        n_value_start = 1'b1;
                        n_host_value  = c_host_active;
                        n_phase       = hhf_pkg::PH_VALUE;
                    end
                end
                hhf_pkg::PH_VALUE: begin
                    if (ch == hhf_pkg::CH_CR) begin
                        n_role  = hhf_pkg::ROLE_EOL;
                        n_phase = hhf_pkg::PH_CR;
                    end else if (ch == hhf_pkg::CH_LF) begin
                        bad = 1'b1;
                    end else begin
                        n_role       = hhf_pkg::ROLE_VALUE;
                        n_host_value = c_host_active;
                    end
                end
                hhf_pkg::PH_CREMPTY: begin
                    if (ch == hhf_pkg::CH_LF) begin
                        n_role      = hhf_pkg::ROLE_FINAL;
                        n_head_done = 1'b1;
                        n_phase     = hhf_pkg::PH_DONE;
                    end else begin
                        bad = 1'b1;
                    end
                end
                default: begin
                    // anything after the blank line
                    bad = 1'b1;
                end
            endcase

            // error wipes this byte's flags and freezes the phase
            if (bad) begin
                n_error       = 1'b1;
                n_phase       = c_phase;
                n_role        = hhf_pkg::ROLE_START;
                n_name_start  = 1'b0;
                n_value_start = 1'b0;
                n_host_value  = 1'b0;
                n_head_done   = 1'b0;
            end
        end

        n_status_code  = r_response_mode ? n_accum : 16'd0;
        n_status_valid = r_response_mode && (n_phase != hhf_pkg::PH_START);
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take && i_in_valid) begin
            r_in_byte <= i_data_byte;
            r_in_new  <= i_new_message;
        end
    end

    // parse state, updated once per item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= hhf_pkg::PH_START;
            r_spaces      <= 2'd0;
            r_accum       <= 16'd0;
            r_digits_open <= 1'b1;
            r_match_cnt   <= 3'd0;
            r_mismatch    <= 1'b0;
            r_host_active <= 1'b0;
            r_error       <= 1'b0;
        end else if (advance) begin
            r_phase       <= n_phase;
            r_spaces      <= n_spaces;
            r_accum       <= n_accum;
            r_digits_open <= n_digits_open;
            r_match_cnt   <= n_match_cnt;
            r_mismatch    <= n_mismatch;
            r_host_active <= n_host_active;
            r_error       <= n_error;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_role         <= n_role;
            r_name_start   <= n_name_start;
            r_value_start  <= n_value_start;
            r_host_value   <= n_host_value;
            r_status_code  <= n_status_code;
            r_status_valid <= n_status_valid;
            r_parse_error  <= n_error;
            r_head_done    <= n_head_done;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_byte_role    = r_role;
    assign o_name_start   = r_name_start;
    assign o_value_start  = r_value_start;
    assign o_host_value   = r_host_value;
    assign o_status_code  = r_status_code;
    assign o_status_valid = r_status_valid;
    assign o_parse_error  = r_parse_error;
    assign o_head_done    = r_head_done;

endmodule
